// ----- hdl/trimmed_blur_3x3_assert.svh -----
// ----------------------------------------------------------------------------
// trimmed_blur_3x3 assertion macros
// concurrent checks on clk_i, held off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef TRIMMED_BLUR_3X3_ASSERT_SVH
`define TRIMMED_BLUR_3X3_ASSERT_SVH

`ifndef ASSERT_OFF
`define TB3_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`define TB3_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define TB3_ASSERT(name, prop, msg)
`define TB3_ASSERT_NEVER(name, cond, msg)
`endif

`endif

// ----- hdl/tblur3_pkg.sv -----
// ----------------------------------------------------------------------------
// tblur3_pkg
// shared types and constants of the trimmed-mean 3x3 filter
// ----------------------------------------------------------------------------
package tblur3_pkg;

  localparam int MAX_SIDE_DEF = 1024;
  localparam int SIDE_W       = 11;
  localparam int SIDE_RESET   = 1024;
  localparam int CHAN_W       = 8;
  localparam int WIN_N        = 9;
  localparam int LUM_W        = 10;
  localparam int SUM_W        = 12;
  localparam int TRIM_W       = 11;
  localparam int FIFO_DEPTH   = 8;

  // divide by 7 as multiply by ceil(2^16 / 7), exact for values below 13107
  localparam int DIV7_MUL     = 9363;
  localparam int DIV7_MUL_W   = 14;
  localparam int DIV7_SHIFT   = 16;

  typedef struct packed {
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] r;
  } rgb_t;

  typedef rgb_t [WIN_N-1:0] win_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_MEAN,
    RES_CENTER,
    RES_UPPER,
    RES_MIDDLE
  } res_kind_e;

  typedef struct packed {
    logic mean;
    logic frame_end;
    rgb_t pix;
  } res_info_t;

  typedef struct packed {
    logic frame_end;
    rgb_t pix;
  } res_out_t;

endpackage

// ----- hdl/trimmed_blur_3x3.sv -----
// ----------------------------------------------------------------------------
// trimmed_blur_3x3: trimmed-mean 3x3 filter on a square rgb raster stream
// throughput one request per cycle while in_ready_o is high (result credit left);
// each line store does one read and one write a cycle; 8 in flight
// reset: side 1024, positions and window cleared, line stores keep contents
// ----------------------------------------------------------------------------
`include "trimmed_blur_3x3_assert.svh"

module trimmed_blur_3x3 #(
  parameter int MAX_SIDE  = tblur3_pkg::MAX_SIDE_DEF,
  parameter int OUT_DEPTH = tblur3_pkg::FIFO_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tblur3_pkg::SIDE_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [tblur3_pkg::CHAN_W-1:0] red_in_i,
  input  logic [tblur3_pkg::CHAN_W-1:0] green_in_i,
  input  logic [tblur3_pkg::CHAN_W-1:0] blue_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tblur3_pkg::CHAN_W-1:0] red_out_o,
  output logic [tblur3_pkg::CHAN_W-1:0] green_out_o,
  output logic [tblur3_pkg::CHAN_W-1:0] blue_out_o,
  output logic                          frame_end_o
);
  import tblur3_pkg::*;

  localparam int PW       = $clog2(MAX_SIDE);
  localparam int PDW      = $clog2(MAX_SIDE + 2);
  localparam int SW       = $clog2(MAX_SIDE + 1);
  localparam int CW       = ((SW > SIDE_W) ? SW : SIDE_W) + 1;
  localparam int SIDE_RST = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
  localparam int CNT_W    = $clog2(OUT_DEPTH + 1);

  // side
  logic [CW-1:0]  side_raw, side_c;
  logic [PW-1:0]  side_m1_q, side_m1_d;
  logic [PDW-1:0] side_p1_q, side_p1_d;

  // positions and pending count
  logic [PW-1:0]  ic_q, ic_d, oc_q, oc_d, or_q, or_d;
  logic [PDW-1:0] pend_q, pend_d;
  logic           in_fire, inner, full, oc_last, or_last, ic_last, adv_out, fe_d;
  res_kind_e      kind_d;
  logic           wr_d;
  logic [PW-1:0]  rd_addr;

  // stage 1
  res_kind_e      s1_kind_q;
  logic           s1_wr_q, s1_fe_q;
  logic [PW-1:0]  s1_addr_q;
  rgb_t           s1_pix_q;

  // line stores and forwarding
  rgb_t           upper_mem [MAX_SIDE];
  rgb_t           middle_mem [MAX_SIDE];
  rgb_t           up_rd_q, mid_rd_q, fwd_up_q, fwd_mid_q, up_eff, mid_eff;
  logic           fwd_q, fwd_d;

  // window
  win_t           win_q, win_d;
  res_info_t      s1_info;
  logic           s1_res;
  logic           s1_win_res;

  // back end
  logic           mean_v;
  res_out_t       mean_res, out_data;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic           res_in, res_out;

  always_comb begin
    side_raw = CW'(cfg_wdata_i);
    if (side_raw == '0) begin
      side_c = CW'(1);
    end else if (side_raw > CW'(MAX_SIDE)) begin
      side_c = CW'(MAX_SIDE);
    end else begin
      side_c = side_raw;
    end
    side_m1_d = PW'(side_c - CW'(1));
    side_p1_d = PDW'(side_c + CW'(1));
  end

  assign in_ready_o = (cnt_q < CNT_W'(OUT_DEPTH));
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    inner   = (or_q != '0) && (or_q < side_m1_q) && (oc_q != '0) && (oc_q < side_m1_q);
    full    = (pend_q == side_p1_q);
    oc_last = (oc_q == side_m1_q);
    or_last = (or_q == side_m1_q);
    ic_last = (ic_q == side_m1_q);
    fe_d    = oc_last && or_last;
    rd_addr = mode_i ? oc_q : ic_q;
    ic_d    = ic_q;
    oc_d    = oc_q;
    or_d    = or_q;
    pend_d  = pend_q;
    kind_d  = RES_NONE;
    wr_d    = 1'b0;
    adv_out = 1'b0;
    if (cfg_we_i) begin
      ic_d   = '0;
      oc_d   = '0;
      or_d   = '0;
      pend_d = '0;
    end else if (in_fire) begin
      if (mode_i) begin
        if ((pend_q != '0) && !inner) begin
          kind_d  = full ? RES_UPPER : RES_MIDDLE;
          pend_d  = pend_q - PDW'(1);
          adv_out = 1'b1;
        end
      end else begin
        wr_d = 1'b1;
        ic_d = ic_last ? '0 : ic_q + PW'(1);
        if (full) begin
          kind_d  = inner ? RES_MEAN : RES_CENTER;
          adv_out = 1'b1;
        end else begin
          pend_d = pend_q + PDW'(1);
        end
      end
      if (adv_out) begin
        oc_d = oc_last ? '0 : oc_q + PW'(1);
        if (oc_last) begin
          or_d = or_last ? '0 : or_q + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_m1_q <= PW'(SIDE_RST - 1);
      side_p1_q <= PDW'(SIDE_RST + 1);
      ic_q      <= '0;
      oc_q      <= '0;
      or_q      <= '0;
      pend_q    <= '0;
      s1_kind_q <= RES_NONE;
      s1_wr_q   <= 1'b0;
      fwd_q     <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        side_m1_q <= side_m1_d;
        side_p1_q <= side_p1_d;
      end
      ic_q      <= ic_d;
      oc_q      <= oc_d;
      or_q      <= or_d;
      pend_q    <= pend_d;
      s1_kind_q <= kind_d;
      s1_wr_q   <= wr_d;
      fwd_q     <= fwd_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= ic_q;
    s1_fe_q   <= fe_d;
    s1_pix_q  <= '{b: blue_in_i, g: green_in_i, r: red_in_i};
    fwd_up_q  <= mid_eff;
    fwd_mid_q <= s1_pix_q;
  end

  // write of the previous request lands on the same edge as this read
  assign fwd_d   = s1_wr_q && (s1_addr_q == rd_addr);
  assign up_eff  = fwd_q ? fwd_up_q : up_rd_q;
  assign mid_eff = fwd_q ? fwd_mid_q : mid_rd_q;

  always_ff @(posedge clk_i) begin
    up_rd_q <= upper_mem[rd_addr];
    if (s1_wr_q) begin
      upper_mem[s1_addr_q] <= mid_eff;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_rd_q <= middle_mem[rd_addr];
    if (s1_wr_q) begin
      middle_mem[s1_addr_q] <= s1_pix_q;
    end
  end

  always_comb begin
    win_d    = win_q;
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = up_eff;
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = mid_eff;
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_wr_q) begin
      win_q <= win_d;
    end
  end

  always_comb begin
    s1_res            = (s1_kind_q != RES_NONE);
    s1_win_res        = (s1_kind_q == RES_MEAN) || (s1_kind_q == RES_CENTER);
    s1_info.mean      = (s1_kind_q == RES_MEAN);
    s1_info.frame_end = s1_fe_q;
    case (s1_kind_q)
      RES_UPPER:  s1_info.pix = up_eff;
      RES_MIDDLE: s1_info.pix = mid_eff;
      default:    s1_info.pix = win_d[4];
    endcase
  end

  tblur3_mean u_mean (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_res),
    .info_i  (s1_info),
    .win_i   (win_d),
    .valid_o (mean_v),
    .res_o   (mean_res)
  );

  tblur3_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (mean_v),
    .wdata_i (mean_res),
    .rd_en_i (res_out),
    .valid_o (out_valid_o),
    .rdata_o (out_data)
  );

  // results admitted but not yet taken, bounded by the buffer depth
  assign res_in  = (kind_d != RES_NONE);
  assign res_out = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (res_in && !res_out) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!res_in && res_out) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  assign red_out_o   = out_data.pix.r;
  assign green_out_o = out_data.pix.g;
  assign blue_out_o  = out_data.pix.b;
  assign frame_end_o = out_data.frame_end;

  `TB3_ASSERT(a_pend_range, pend_q <= side_p1_q, "pending count beyond one row plus one")
  `TB3_ASSERT(a_out_pos, (oc_q <= side_m1_q) && (or_q <= side_m1_q), "output position beyond side")
  `TB3_ASSERT(a_in_pos, ic_q <= side_m1_q, "input position beyond side")
  `TB3_ASSERT(a_out_credit, out_valid_o |-> (cnt_q != '0), "buffered result without credit")
  `TB3_ASSERT_NEVER(a_win_result, s1_win_res && !s1_wr_q, "window result without pixel")

endmodule

// ----- hdl/tblur3_mean.sv -----
// ----------------------------------------------------------------------------
// tblur3_mean
// three-stage trimmed mean of a 3x3 window: min/max search and channel sums,
// trim, then divide by 7; border values ride along unchanged
// ----------------------------------------------------------------------------
module tblur3_mean (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  tblur3_pkg::res_info_t info_i,
  input  tblur3_pkg::win_t      win_i,
  output logic                  valid_o,
  output tblur3_pkg::res_out_t  res_o
);
  import tblur3_pkg::*;

  localparam int MULT_W = TRIM_W + DIV7_MUL_W;

  // stage a: window capture
  logic      a_v_q;
  res_info_t a_info_q;
  win_t      a_win_q;

  // stage b: sums and extremes
  logic              b_v_q;
  res_info_t         b_info_q;
  logic [SUM_W-1:0]  b_sum_r_q, b_sum_g_q, b_sum_b_q;
  rgb_t              b_lo_q, b_hi_q;

  // stage c: trimmed sums
  logic              c_v_q;
  res_info_t         c_info_q;
  logic [TRIM_W-1:0] c_t_r_q, c_t_g_q, c_t_b_q;

  logic [LUM_W-1:0]  lum [WIN_N];
  logic [LUM_W-1:0]  lo_s, hi_s;
  rgb_t              lo_p, hi_p;
  logic [SUM_W-1:0]  sum_r, sum_g, sum_b;
  logic [TRIM_W-1:0] t_r, t_g, t_b;
  logic [MULT_W-1:0] prod_r, prod_g, prod_b;
  rgb_t              mean_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_info_q  <= info_i;
    a_win_q   <= win_i;
    b_info_q  <= a_info_q;
    b_sum_r_q <= sum_r;
    b_sum_g_q <= sum_g;
    b_sum_b_q <= sum_b;
    b_lo_q    <= lo_p;
    b_hi_q    <= hi_p;
    c_info_q  <= b_info_q;
    c_t_r_q   <= t_r;
    c_t_g_q   <= t_g;
    c_t_b_q   <= t_b;
  end

  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      lum[i] = LUM_W'(a_win_q[i].r) + LUM_W'(a_win_q[i].g) + LUM_W'(a_win_q[i].b);
    end
  end

  // minimum keeps the last tie, maximum the first
  always_comb begin
    lo_s = lum[0];
    hi_s = lum[0];
    lo_p = a_win_q[0];
    hi_p = a_win_q[0];
    for (int i = 1; i < WIN_N; i++) begin
      if (lum[i] <= lo_s) begin
        lo_s = lum[i];
        lo_p = a_win_q[i];
      end
      if (lum[i] > hi_s) begin
        hi_s = lum[i];
        hi_p = a_win_q[i];
      end
    end
  end

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int i = 0; i < WIN_N; i++) begin
      sum_r = sum_r + SUM_W'(a_win_q[i].r);
      sum_g = sum_g + SUM_W'(a_win_q[i].g);
      sum_b = sum_b + SUM_W'(a_win_q[i].b);
    end
  end

  always_comb begin
    t_r = TRIM_W'(b_sum_r_q - SUM_W'(b_lo_q.r) - SUM_W'(b_hi_q.r));
    t_g = TRIM_W'(b_sum_g_q - SUM_W'(b_lo_q.g) - SUM_W'(b_hi_q.g));
    t_b = TRIM_W'(b_sum_b_q - SUM_W'(b_lo_q.b) - SUM_W'(b_hi_q.b));
  end

  always_comb begin
    prod_r     = MULT_W'(c_t_r_q) * MULT_W'(DIV7_MUL);
    prod_g     = MULT_W'(c_t_g_q) * MULT_W'(DIV7_MUL);
    prod_b     = MULT_W'(c_t_b_q) * MULT_W'(DIV7_MUL);
    mean_pix.r = prod_r[DIV7_SHIFT +: CHAN_W];
    mean_pix.g = prod_g[DIV7_SHIFT +: CHAN_W];
    mean_pix.b = prod_b[DIV7_SHIFT +: CHAN_W];
  end

  assign valid_o         = c_v_q;
  assign res_o.frame_end = c_info_q.frame_end;
  assign res_o.pix       = c_info_q.mean ? mean_pix : c_info_q.pix;

endmodule

// ----- hdl/tblur3_fifo.sv -----
// ----------------------------------------------------------------------------
// tblur3_fifo
// small result buffer in front of the output port
// ----------------------------------------------------------------------------
module tblur3_fifo #(
  parameter int DEPTH = tblur3_pkg::FIFO_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  tblur3_pkg::res_out_t wdata_i,
  input  logic                 rd_en_i,
  output logic                 valid_o,
  output tblur3_pkg::res_out_t rdata_o
);
  import tblur3_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_out_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem[rd_ptr_q];

endmodule

// ----- test/tb_trimmed_blur_3x3.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trimmed_blur_3x3
// self-checking bench for the trimmed-mean 3x3 filter: pixel and flush
// requests with random idle gaps on both channels, every result checked
// against a behavioral filter that keeps its own line stores and window
// ----------------------------------------------------------------------------
module tb_trimmed_blur_3x3;
  import tblur3_pkg::*;

  localparam int MAX_SIDE     = MAX_SIDE_DEF;
  localparam int TRIM_DIV     = 7;
  localparam int DRAIN_CYCLES = 24;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RAND_ITEMS   = 500;

  typedef struct packed {
    logic flush;
    rgb_t px;
  } pix_req_t;

  typedef enum int {
    PX_RANDOM,
    PX_EXTREME,
    PX_NEAR
  } px_style_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [SIDE_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic              mode_i      = 1'b0;
  logic [CHAN_W-1:0] red_in_i    = '0;
  logic [CHAN_W-1:0] green_in_i  = '0;
  logic [CHAN_W-1:0] blue_in_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CHAN_W-1:0] red_out_o;
  logic [CHAN_W-1:0] green_out_o;
  logic [CHAN_W-1:0] blue_out_o;
  logic              frame_end_o;

  // filter state mirror
  logic [SIDE_W-1:0] side_reg;
  rgb_t              up_mem  [MAX_SIDE];
  rgb_t              mid_mem [MAX_SIDE];
  rgb_t              win_px  [WIN_N];
  int unsigned       in_row, in_col, out_row, out_col, pend_cnt;

  pix_req_t    pix_req_q[$];
  res_out_t    filtered_q[$];
  logic        req_busy  = 1'b0;
  logic        idle_on   = 1'b1;
  int unsigned req_gap   = 0;
  int unsigned rsp_gap   = 0;
  int unsigned quiet_cnt = 0;
  int          err_cnt   = 0;

  trimmed_blur_3x3 u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .frame_end_o (frame_end_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (!idle_on) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int unsigned active_side();
    if (side_reg == '0) return 1;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return side_reg;
  endfunction

  function automatic int unsigned luma(input rgb_t p);
    return int'(p.r) + int'(p.g) + int'(p.b);
  endfunction

  // drop darkest (last on ties) and brightest (first on ties), average the rest
  function automatic rgb_t trimmed_mean();
    int unsigned lo, hi, lo_s, hi_s, s, sum_r, sum_g, sum_b;
    rgb_t res;
    lo = 0;
    hi = 0;
    lo_s = luma(win_px[0]);
    hi_s = lo_s;
    for (int i = 1; i < WIN_N; i++) begin
      s = luma(win_px[i]);
      if (s <= lo_s) begin
        lo_s = s;
        lo = i;
      end
      if (s > hi_s) begin
        hi_s = s;
        hi = i;
      end
    end
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (int i = 0; i < WIN_N; i++) begin
      sum_r += win_px[i].r;
      sum_g += win_px[i].g;
      sum_b += win_px[i].b;
    end
    sum_r = sum_r - win_px[lo].r - win_px[hi].r;
    sum_g = sum_g - win_px[lo].g - win_px[hi].g;
    sum_b = sum_b - win_px[lo].b - win_px[hi].b;
    res.r = 8'(sum_r / TRIM_DIV);
    res.g = 8'(sum_g / TRIM_DIV);
    res.b = 8'(sum_b / TRIM_DIV);
    return res;
  endfunction

  task automatic next_pos(inout int unsigned row, inout int unsigned col,
                          input int unsigned sd);
    col++;
    if (col >= sd) begin
      col = 0;
      row++;
      if (row >= sd) row = 0;
    end
  endtask

  task automatic queue_result(input rgb_t val, input int unsigned sd);
    res_out_t res;
    res.pix = val;
    res.frame_end = (out_row == sd - 1) && (out_col == sd - 1);
    filtered_q.push_back(res);
    next_pos(out_row, out_col, sd);
  endtask

  task automatic filter_step(input pix_req_t req);
    int unsigned sd;
    logic emit, inner;
    rgb_t val, top, mid;
    sd = active_side();
    out_col %= sd;
    in_col %= sd;
    in_row %= sd;
    out_row %= sd;
    inner = out_row >= 1 && out_row + 2 <= sd && out_col >= 1 && out_col + 2 <= sd;
    val = '0;
    if (req.flush) begin
      if (pend_cnt != 0 && !inner) begin
        val = (pend_cnt == sd + 1) ? up_mem[out_col] : mid_mem[out_col];
        pend_cnt--;
        queue_result(val, sd);
      end
    end else begin
      emit = (pend_cnt == sd + 1);
      if (emit && !inner) val = up_mem[out_col];
      top = up_mem[in_col];
      mid = mid_mem[in_col];
      up_mem[in_col] = mid;
      mid_mem[in_col] = req.px;
      for (int r = 0; r < 3; r++) begin
        win_px[r*3]     = win_px[r*3 + 1];
        win_px[r*3 + 1] = win_px[r*3 + 2];
      end
      win_px[2] = top;
      win_px[5] = mid;
      win_px[8] = req.px;
      next_pos(in_row, in_col, sd);
      if (!emit) begin
        pend_cnt++;
      end else begin
        if (inner) val = trimmed_mean();
        queue_result(val, sd);
      end
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    pix_req_t cur;
    pix_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_busy = 1'b0;
      req_gap = 0;
      side_reg = SIDE_W'(SIDE_RESET);
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
      pend_cnt = 0;
      foreach (win_px[i]) win_px[i] = '0;
      foreach (up_mem[i]) begin
        up_mem[i] = '0;
        mid_mem[i] = '0;
      end
    end else begin
      if (cfg_we_i) begin
        side_reg = cfg_wdata_i;
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
        pend_cnt = 0;
      end
      if (in_valid_i && in_ready_o) begin
        cur.flush = mode_i;
        cur.px.r = red_in_i;
        cur.px.g = green_in_i;
        cur.px.b = blue_in_i;
        filter_step(cur);
        req_busy = 1'b0;
        req_gap = pick_gap();
      end
      if (!req_busy) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (pix_req_q.size() > 0) begin
          nxt = pix_req_q.pop_front();
          mode_i <= nxt.flush;
          red_in_i <= nxt.px.r;
          green_in_i <= nxt.px.g;
          blue_in_i <= nxt.px.b;
          req_busy = 1'b1;
        end
      end
      in_valid_i <= req_busy;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    res_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rsp_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected result: red %0d green %0d blue %0d frame_end %0b",
                 red_out_o, green_out_o, blue_out_o, frame_end_o);
          err_cnt++;
        end else begin
          want = filtered_q.pop_front();
          if (red_out_o !== want.pix.r) begin
            $error("red_out: expected %0d, got %0d", want.pix.r, red_out_o);
            err_cnt++;
          end
          if (green_out_o !== want.pix.g) begin
            $error("green_out: expected %0d, got %0d", want.pix.g, green_out_o);
            err_cnt++;
          end
          if (blue_out_o !== want.pix.b) begin
            $error("blue_out: expected %0d, got %0d", want.pix.b, blue_out_o);
            err_cnt++;
          end
          if (frame_end_o !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end_o);
            err_cnt++;
          end
        end
        rsp_gap = pick_gap();
      end
      if (rsp_gap > 0) begin
        rsp_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  task automatic push_pix(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                          input logic [CHAN_W-1:0] b);
    pix_req_t req;
    req.flush = 1'b0;
    req.px.r = r;
    req.px.g = g;
    req.px.b = b;
    pix_req_q.push_back(req);
  endtask

  task automatic push_flush();
    pix_req_t req;
    req = '0;
    req.flush = 1'b1;
    pix_req_q.push_back(req);
  endtask

  task automatic push_rand(input px_style_e style);
    rgb_t p;
    case (style)
      PX_EXTREME: begin
        p.r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      PX_NEAR: begin
        // narrow range, lots of brightness ties
        p.r = 8'($urandom_range(84, 87));
        p.g = 8'($urandom_range(84, 87));
        p.b = 8'($urandom_range(84, 87));
      end
      default: begin
        p = rgb_t'(24'($urandom));
      end
    endcase
    push_pix(p.r, p.g, p.b);
  endtask

  // all requests taken, all results seen, then room for flushes with no result
  task automatic wait_idle();
    while (!(pix_req_q.size() == 0 && !req_busy && filtered_q.size() == 0))
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_side(input int unsigned v);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= SIDE_W'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned rand_items, sd, n, wval, sel, lr, lg;
    px_style_e style;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset side: flush with nothing pending, channel extremes, border flushes
    push_flush();
    push_pix(8'h00, 8'h00, 8'h00);
    push_pix(8'hFF, 8'hFF, 8'hFF);
    push_pix(8'hFF, 8'h00, 8'h00);
    push_pix(8'h00, 8'hFF, 8'h00);
    push_pix(8'h00, 8'h00, 8'hFF);
    push_pix(8'hAA, 8'h55, 8'hAA);
    push_pix(8'h55, 8'hAA, 8'h55);
    push_flush();
    push_flush();
    // top row is all border, so flushes give the pixels back
    repeat (24) push_rand(PX_RANDOM);
    repeat (8) push_flush();

    // above the largest side
    write_side(2047);
    repeat (30) push_rand(PX_RANDOM);
    repeat (32) push_flush();

    // side 3: single interior pixel over nine pixels of equal brightness
    write_side(3);
    repeat (9) begin
      lr = $urandom_range(0, 30);
      lg = $urandom_range(0, 30 - lr);
      push_pix(8'(lr), 8'(lg), 8'(30 - lr - lg));
    end
    repeat (9) push_rand(PX_RANDOM);
    repeat (5) push_flush();

    // zero acts as side 1
    write_side(0);
    repeat (6) push_rand(PX_RANDOM);
    repeat (3) push_flush();

    write_side(1);
    repeat (5) push_rand(PX_EXTREME);
    repeat (2) push_flush();

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) wval = $urandom_range(0, 2);
      else if (sel < 55) wval = $urandom_range(3, 6);
      else wval = $urandom_range(7, 16);
      sd = (wval == 0) ? 1 : wval;
      n = sd * sd * ((sd > 8) ? 1 : $urandom_range(1, 3));
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      sel = $urandom_range(0, 9);
      if (sel < 6) style = PX_RANDOM;
      else if (sel < 8) style = PX_EXTREME;
      else style = PX_NEAR;
      write_side(wval);
      idle_on = ($urandom_range(0, 4) != 0);
      repeat (n) begin
        if ($urandom_range(0, 24) == 0) push_flush();
        push_rand(style);
      end
      // otherwise the next side write drops what is pending
      if ($urandom_range(0, 3) != 0) repeat (sd + 2) push_flush();
      rand_items += n;
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
